FILE: sv/mse_pkg.sv
// mse_pkg: sizes, codes and constants of the multi-stack engine.
// No dependencies; used by multi_stack_engine.
package mse_pkg;

  localparam int unsigned NUM_STACKS   = 4;
  localparam int unsigned STACK_DEPTH  = 16;

  localparam int unsigned NUM_CAP_REGS = 4;
  localparam int unsigned CAP_IDX_W    = 2;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CAP_W        = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEVEL_W  = 5;

  localparam int unsigned STK_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned PTR_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LVL_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
  localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned CMP_W     = (LVL_W > CAP_W) ? LVL_W : CAP_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_DUMP  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_BADID = 2'd3
  } status_e;

endpackage

FILE: sv/multi_stack_engine.sv
// multi_stack_engine: several bounded LIFO stacks of signed 32-bit values
// sharing one synchronous memory. Depends on mse_pkg.
//
// Usage: an operation is taken when start_i is high and busy_o is low. Push,
// clear and every rejected operation (bad id, full, empty) hold busy_o low, so
// a new operation can be taken in the next cycle; each gives one result in the
// cycle after it is taken. A pop reads the memory into a read register, then
// gives its result from ST_POP. A dump of a stack with L entries reads one entry
// per cycle from the memory's single read port, giving L results bottom first
// on consecutive cycles, last_o marking the top entry. Results are strobed by
// result_valid_o for one cycle each and cannot be held off. Capacity registers
// are written through the cfg port (always ready); write them only while idle.
// No clearing pass follows reset.
module multi_stack_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [mse_pkg::MODE_W-1:0]        mode_i,
  input  logic [mse_pkg::ID_W-1:0]          stack_id_i,
  input  logic signed [mse_pkg::VAL_W-1:0]  push_value_i,
  output logic                              result_valid_o,
  output logic signed [mse_pkg::VAL_W-1:0]  out_value_o,
  output logic [mse_pkg::STATUS_W-1:0]      status_o,
  output logic [mse_pkg::LEVEL_W-1:0]       level_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mse_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mse_pkg::CAP_W-1:0]         cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DUMP
  } state_e;

  state_e state_q, state_d;

  logic [mse_pkg::CAP_W-1:0] cap_q [mse_pkg::NUM_CAP_REGS];
  logic [mse_pkg::LVL_W-1:0] level_q [mse_pkg::NUM_STACKS];

  logic signed [mse_pkg::VAL_W-1:0] stack_mem_q [mse_pkg::MEM_DEPTH];
  logic signed [mse_pkg::VAL_W-1:0] rdata_q;

  logic                              rvalid_q, rvalid_d;
  logic signed [mse_pkg::VAL_W-1:0]  value_q, value_d;
  logic [mse_pkg::STATUS_W-1:0]      status_q, status_d;
  logic [mse_pkg::LEVEL_W-1:0]       lvl_out_q, lvl_out_d;
  logic                              last_q, last_d;
  logic [mse_pkg::LVL_W-1:0]         op_lvl_q, op_lvl_d;
  logic [mse_pkg::ADDR_W-1:0]        base_q, base_d;
  logic [mse_pkg::PTR_W-1:0]         dump_idx_q, dump_idx_d;

  logic                              accept;
  logic                              id_ok;
  logic [mse_pkg::STK_IDX_W-1:0]     sid;
  logic [mse_pkg::LVL_W-1:0]         sel_lvl;
  logic [mse_pkg::CAP_W-1:0]         cap_raw;
  logic [mse_pkg::CMP_W-1:0]         cap_eff;
  logic [mse_pkg::ADDR_W-1:0]        base;
  logic                              dump_last;

  logic                              lvl_we;
  logic [mse_pkg::LVL_W-1:0]         lvl_wdata;
  logic                              mem_we, mem_re;
  logic [mse_pkg::ADDR_W-1:0]        mem_waddr, mem_raddr;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign id_ok   = ({1'b0, stack_id_i} < (mse_pkg::ID_W+1)'(mse_pkg::NUM_STACKS));
  assign sid     = stack_id_i[mse_pkg::STK_IDX_W-1:0];
  assign sel_lvl = level_q[sid];
  assign base    = mse_pkg::ADDR_W'(sid) * mse_pkg::ADDR_W'(mse_pkg::STACK_DEPTH);

  always_comb begin
    cap_raw = mse_pkg::CAP_W'(mse_pkg::STACK_DEPTH);
    if ({1'b0, stack_id_i} < (mse_pkg::ID_W+1)'(mse_pkg::NUM_CAP_REGS)) begin
      cap_raw = cap_q[stack_id_i[mse_pkg::CAP_IDX_W-1:0]];
    end
    cap_eff = mse_pkg::CMP_W'(cap_raw);
    if (cap_eff > mse_pkg::CMP_W'(mse_pkg::STACK_DEPTH)) begin
      cap_eff = mse_pkg::CMP_W'(mse_pkg::STACK_DEPTH);
    end
  end

  assign dump_last = (mse_pkg::LVL_W'(dump_idx_q) + mse_pkg::LVL_W'(1) == op_lvl_q);

  always_comb begin
    state_d    = state_q;
    rvalid_d   = 1'b0;
    value_d    = '0;
    status_d   = mse_pkg::STATUS_OK;
    lvl_out_d  = '0;
    last_d     = 1'b1;
    op_lvl_d   = op_lvl_q;
    base_d     = base_q;
    dump_idx_d = dump_idx_q;
    lvl_we     = 1'b0;
    lvl_wdata  = sel_lvl;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = base + mse_pkg::ADDR_W'(sel_lvl);
    mem_raddr  = base;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!id_ok) begin
            rvalid_d = 1'b1;
            status_d = mse_pkg::STATUS_BADID;
          end else begin
            case (mse_pkg::mode_e'(mode_i))
              mse_pkg::MODE_PUSH: begin
                rvalid_d = 1'b1;
                if (mse_pkg::CMP_W'(sel_lvl) >= cap_eff) begin
                  status_d  = mse_pkg::STATUS_FULL;
                  lvl_out_d = mse_pkg::LEVEL_W'(sel_lvl);
                end else begin
                  mem_we    = 1'b1;
                  lvl_we    = 1'b1;
                  lvl_wdata = sel_lvl + mse_pkg::LVL_W'(1);
                  lvl_out_d = mse_pkg::LEVEL_W'(sel_lvl + mse_pkg::LVL_W'(1));
                end
              end
              mse_pkg::MODE_POP: begin
                if (sel_lvl == '0) begin
                  rvalid_d = 1'b1;
                  status_d = mse_pkg::STATUS_EMPTY;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = base + mse_pkg::ADDR_W'(sel_lvl - mse_pkg::LVL_W'(1));
                  lvl_we    = 1'b1;
                  lvl_wdata = sel_lvl - mse_pkg::LVL_W'(1);
                  op_lvl_d  = sel_lvl - mse_pkg::LVL_W'(1);
                  state_d   = ST_POP;
                end
              end
              mse_pkg::MODE_DUMP: begin
                if (sel_lvl == '0) begin
                  rvalid_d = 1'b1;
                  status_d = mse_pkg::STATUS_EMPTY;
                end else begin
                  mem_re     = 1'b1;
                  mem_raddr  = base;
                  base_d     = base;
                  op_lvl_d   = sel_lvl;
                  dump_idx_d = '0;
                  state_d    = ST_DUMP;
                end
              end
              mse_pkg::MODE_CLEAR: begin
                rvalid_d = 1'b1;
                if (sel_lvl == '0) begin
                  status_d = mse_pkg::STATUS_EMPTY;
                end else begin
                  lvl_we    = 1'b1;
                  lvl_wdata = '0;
                end
              end
              default: begin
                rvalid_d = 1'b1;
              end
            endcase
          end
        end
      end
      ST_POP: begin
        rvalid_d  = 1'b1;
        value_d   = rdata_q;
        lvl_out_d = mse_pkg::LEVEL_W'(op_lvl_q);
        state_d   = ST_IDLE;
      end
      ST_DUMP: begin
        rvalid_d  = 1'b1;
        value_d   = rdata_q;
        lvl_out_d = mse_pkg::LEVEL_W'(op_lvl_q);
        last_d    = dump_last;
        if (dump_last) begin
          dump_idx_d = '0;
          state_d    = ST_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = base_q + mse_pkg::ADDR_W'(dump_idx_q + mse_pkg::PTR_W'(1));
          dump_idx_d = dump_idx_q + mse_pkg::PTR_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rvalid_q   <= 1'b0;
      dump_idx_q <= '0;
      for (int i = 0; i < mse_pkg::NUM_CAP_REGS; i++) begin
        cap_q[i] <= mse_pkg::CAP_RESET;
      end
      for (int i = 0; i < mse_pkg::NUM_STACKS; i++) begin
        level_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      rvalid_q   <= rvalid_d;
      dump_idx_q <= dump_idx_d;
      if (cfg_valid_i && cfg_ready_o &&
          ({1'b0, cfg_index_i} < (mse_pkg::CFG_IDX_W+1)'(mse_pkg::NUM_CAP_REGS))) begin
        cap_q[cfg_index_i[mse_pkg::CAP_IDX_W-1:0]] <= cfg_data_i;
      end
      if (lvl_we) begin
        level_q[sid] <= lvl_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    status_q  <= status_d;
    lvl_out_q <= lvl_out_d;
    last_q    <= last_d;
    op_lvl_q  <= op_lvl_d;
    base_q    <= base_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem_q[mem_waddr] <= push_value_i;
    end
    if (mem_re) begin
      rdata_q <= stack_mem_q[mem_raddr];
    end
  end

  assign result_valid_o = rvalid_q;
  assign out_value_o    = value_q;
  assign status_o       = status_q;
  assign level_o        = lvl_out_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i != mse_pkg::MODE_POP) && (mode_i != mse_pkg::MODE_DUMP)
    |=> result_valid_o && last_o && !busy_o)
    else $error("single-result operation did not complete in one cycle");
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> result_valid_o && last_o && (state_q == ST_IDLE))
    else $error("pop result missing");
  a_dump_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> result_valid_o && (last_o == (state_q == ST_IDLE)))
    else $error("dump stream broken or last misplaced");
  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (mse_pkg::LVL_W'(dump_idx_q) < op_lvl_q))
    else $error("dump index beyond level");
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (level_o <= mse_pkg::LEVEL_W'(mse_pkg::STACK_DEPTH)))
    else $error("level above depth");
`endif

endmodule

FILE: tb/multi_stack_engine_tb.sv
// multi_stack_engine_tb: self-checking bench for the multi-stack engine with
// a stack predictor, queue-fed driver and result monitor. Depends on mse_pkg
// and multi_stack_engine.
module multi_stack_engine_tb;

  typedef struct packed {
    mse_pkg::mode_e                   mode;
    logic [mse_pkg::ID_W-1:0]         id;
    logic signed [mse_pkg::VAL_W-1:0] value;
  } stack_cmd_t;

  typedef struct packed {
    logic signed [mse_pkg::VAL_W-1:0] value;
    mse_pkg::status_e                 status;
    logic [mse_pkg::LEVEL_W-1:0]      level;
    logic                             last;
  } stack_resp_t;

  localparam logic [mse_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED =
    mse_pkg::CFG_IDX_W'(mse_pkg::NUM_CAP_REGS + 1);
  localparam int unsigned RAND_ITEMS = 160;
  localparam int unsigned DRAIN_CYCLES = 2 * mse_pkg::STACK_DEPTH;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             start_i = 1'b0;
  logic                             busy_o;
  logic [mse_pkg::MODE_W-1:0]       mode_i = '0;
  logic [mse_pkg::ID_W-1:0]         stack_id_i = '0;
  logic signed [mse_pkg::VAL_W-1:0] push_value_i = '0;
  logic                             result_valid_o;
  logic signed [mse_pkg::VAL_W-1:0] out_value_o;
  logic [mse_pkg::STATUS_W-1:0]     status_o;
  logic [mse_pkg::LEVEL_W-1:0]      level_o;
  logic                             last_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [mse_pkg::CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [mse_pkg::CAP_W-1:0]        cfg_data_i = '0;

  multi_stack_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .stack_id_i     (stack_id_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .out_value_o    (out_value_o),
    .status_o       (status_o),
    .level_o        (level_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  stack_cmd_t  pending_cmds[$];
  stack_resp_t expected_resp[$];
  stack_cmd_t  cur_cmd;
  int unsigned idle_pct = 0;
  int          mismatch_count = 0;

  logic [mse_pkg::CAP_W-1:0]        cap_q [mse_pkg::NUM_CAP_REGS];
  logic [mse_pkg::LEVEL_W-1:0]      stack_lvl [mse_pkg::NUM_STACKS];
  logic signed [mse_pkg::VAL_W-1:0] stack_mem [mse_pkg::NUM_STACKS][mse_pkg::STACK_DEPTH];

  initial begin
    for (int i = 0; i < mse_pkg::NUM_CAP_REGS; i++) cap_q[i] = mse_pkg::CAP_RESET;
    for (int i = 0; i < mse_pkg::NUM_STACKS; i++) stack_lvl[i] = '0;
  end

  function automatic stack_resp_t mk_resp(logic signed [mse_pkg::VAL_W-1:0] value,
                                          mse_pkg::status_e status,
                                          logic [mse_pkg::LEVEL_W-1:0] level, logic last);
    stack_resp_t r;
    r.value = value;
    r.status = status;
    r.level = level;
    r.last = last;
    return r;
  endfunction

  task automatic apply_stack_op(input stack_cmd_t cmd);
    int unsigned cap;
    int unsigned lvl;
    logic [mse_pkg::STK_IDX_W-1:0] sid;
    if (int'(cmd.id) >= int'(mse_pkg::NUM_STACKS)) begin
      expected_resp.push_back(mk_resp('0, mse_pkg::STATUS_BADID, '0, 1'b1));
      return;
    end
    sid = cmd.id[mse_pkg::STK_IDX_W-1:0];
    lvl = 32'(stack_lvl[sid]);
    if (int'(cmd.id) < int'(mse_pkg::NUM_CAP_REGS))
      cap = 32'(cap_q[cmd.id[mse_pkg::CAP_IDX_W-1:0]]);
    else
      cap = mse_pkg::STACK_DEPTH;
    if (cap > mse_pkg::STACK_DEPTH) cap = mse_pkg::STACK_DEPTH;
    case (cmd.mode)
      mse_pkg::MODE_PUSH: begin
        if (lvl >= cap) begin
          expected_resp.push_back(mk_resp('0, mse_pkg::STATUS_FULL,
                                          mse_pkg::LEVEL_W'(lvl), 1'b1));
        end else begin
          stack_mem[sid][mse_pkg::PTR_W'(lvl)] = cmd.value;
          lvl++;
          stack_lvl[sid] = mse_pkg::LEVEL_W'(lvl);
          expected_resp.push_back(mk_resp('0, mse_pkg::STATUS_OK,
                                          mse_pkg::LEVEL_W'(lvl), 1'b1));
        end
      end
      mse_pkg::MODE_POP: begin
        if (lvl == 0) begin
          expected_resp.push_back(mk_resp('0, mse_pkg::STATUS_EMPTY, '0, 1'b1));
        end else begin
          lvl--;
          stack_lvl[sid] = mse_pkg::LEVEL_W'(lvl);
          expected_resp.push_back(mk_resp(stack_mem[sid][mse_pkg::PTR_W'(lvl)],
                                          mse_pkg::STATUS_OK,
                                          mse_pkg::LEVEL_W'(lvl), 1'b1));
        end
      end
      mse_pkg::MODE_DUMP: begin
        if (lvl == 0) begin
          expected_resp.push_back(mk_resp('0, mse_pkg::STATUS_EMPTY, '0, 1'b1));
        end else begin
          for (int unsigned i = 0; i < lvl; i++)
            expected_resp.push_back(mk_resp(stack_mem[sid][mse_pkg::PTR_W'(i)],
                                            mse_pkg::STATUS_OK,
                                            mse_pkg::LEVEL_W'(lvl), (i + 1 == lvl)));
        end
      end
      default: begin
        if (lvl == 0) begin
          expected_resp.push_back(mk_resp('0, mse_pkg::STATUS_EMPTY, '0, 1'b1));
        end else begin
          stack_lvl[sid] = '0;
          expected_resp.push_back(mk_resp('0, mse_pkg::STATUS_OK, '0, 1'b1));
        end
      end
    endcase
  endtask

  // driver: start_i held until the transfer, then next item or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) apply_stack_op(cur_cmd);
      if (!start_i || !busy_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          start_i <= 1'b1;
          mode_i <= cur_cmd.mode;
          stack_id_i <= cur_cmd.id;
          push_value_i <= cur_cmd.value;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    stack_resp_t got;
    stack_resp_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      got.value = out_value_o;
      got.status = mse_pkg::status_e'(status_o);
      got.level = level_o;
      got.last = last_o;
      if (expected_resp.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result value=%0d status=%0d level=%0d last=%0b",
                 $time, got.value, got.status, got.level, got.last);
      end else begin
        want = expected_resp.pop_front();
        if (got.value !== want.value || got.status !== want.status ||
            got.level !== want.level || got.last !== want.last) begin
          mismatch_count++;
          $display("%0t: mismatch expected value=%0d status=%0d level=%0d last=%0b",
                   $time, want.value, want.status, want.level, want.last);
          $display("%0t:          actual   value=%0d status=%0d level=%0d last=%0b",
                   $time, got.value, got.status, got.level, got.last);
        end
      end
    end
  end

  // capacity register mirror
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o &&
        int'(cfg_index_i) < int'(mse_pkg::NUM_CAP_REGS))
      cap_q[cfg_index_i[mse_pkg::CAP_IDX_W-1:0]] = cfg_data_i;
  end

  task automatic write_capacity(input logic [mse_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mse_pkg::CAP_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_cmd(input mse_pkg::mode_e mode, input logic [mse_pkg::ID_W-1:0] id,
                         input logic signed [mse_pkg::VAL_W-1:0] value);
    stack_cmd_t c;
    c.mode = mode;
    c.id = id;
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  task automatic add_random_cmds(input int unsigned count);
    int unsigned pick;
    mse_pkg::mode_e m;
    logic [mse_pkg::ID_W-1:0] id;
    logic signed [mse_pkg::VAL_W-1:0] v;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50) m = mse_pkg::MODE_PUSH;
      else if (pick < 75) m = mse_pkg::MODE_POP;
      else if (pick < 90) m = mse_pkg::MODE_DUMP;
      else m = mse_pkg::MODE_CLEAR;
      if ($urandom_range(9) == 0)
        id = mse_pkg::ID_W'($urandom_range(mse_pkg::NUM_STACKS, (1 << mse_pkg::ID_W) - 1));
      else
        id = mse_pkg::ID_W'($urandom_range(mse_pkg::NUM_STACKS - 1));
      case ($urandom_range(19))
        0: v = 32'sh7fffffff;
        1: v = 32'sh80000000;
        2: v = '0;
        3: v = -32'sd1;
        default: v = $urandom;
      endcase
      add_cmd(m, id, v);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start_i || expected_resp.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase 1: low, zero and above-depth capacities; sender idles lightly
    write_capacity(3'd0, mse_pkg::CAP_W'(mse_pkg::STACK_DEPTH));
    write_capacity(3'd1, 5'd2);
    write_capacity(3'd2, 5'd0);
    write_capacity(3'd3, 5'd31);
    write_capacity(CFG_IDX_UNUSED, 5'd3);
    idle_pct = 7;
    add_cmd(mse_pkg::MODE_POP, 3'd0, '0);
    add_cmd(mse_pkg::MODE_DUMP, 3'd0, '0);
    add_cmd(mse_pkg::MODE_CLEAR, 3'd0, '0);
    add_cmd(mse_pkg::MODE_PUSH, 3'd7, 32'sh7fffffff);
    add_cmd(mse_pkg::MODE_POP, 3'd4, '0);
    add_cmd(mse_pkg::MODE_DUMP, 3'd5, '0);
    add_cmd(mse_pkg::MODE_CLEAR, 3'd6, '0);
    add_cmd(mse_pkg::MODE_PUSH, 3'd0, 32'sh7fffffff);
    add_cmd(mse_pkg::MODE_PUSH, 3'd0, 32'sh80000000);
    add_cmd(mse_pkg::MODE_PUSH, 3'd0, '0);
    add_cmd(mse_pkg::MODE_PUSH, 3'd0, -32'sd1);
    add_cmd(mse_pkg::MODE_DUMP, 3'd0, '0);
    add_cmd(mse_pkg::MODE_POP, 3'd0, '0);
    add_cmd(mse_pkg::MODE_POP, 3'd0, '0);
    add_cmd(mse_pkg::MODE_CLEAR, 3'd0, '0);
    add_cmd(mse_pkg::MODE_PUSH, 3'd1, 32'sh55555555);
    add_cmd(mse_pkg::MODE_PUSH, 3'd1, 32'shaaaaaaaa);
    add_cmd(mse_pkg::MODE_PUSH, 3'd1, 32'sh12345678);
    add_cmd(mse_pkg::MODE_DUMP, 3'd1, '0);
    add_cmd(mse_pkg::MODE_PUSH, 3'd2, 32'sh00000001);
    add_cmd(mse_pkg::MODE_POP, 3'd2, '0);
    add_random_cmds(RAND_ITEMS);
    add_cmd(mse_pkg::MODE_PUSH, 3'd0, $urandom);
    add_cmd(mse_pkg::MODE_PUSH, 3'd0, $urandom);
    add_cmd(mse_pkg::MODE_PUSH, 3'd0, $urandom);
    wait_drained();

    // phase 2: stack 0 capacity below its level; sender idles heavily
    write_capacity(3'd0, 5'd1);
    write_capacity(3'd1, mse_pkg::CAP_W'(mse_pkg::STACK_DEPTH));
    write_capacity(3'd2, 5'd5);
    write_capacity(3'd3, mse_pkg::CAP_W'(mse_pkg::STACK_DEPTH + 1));
    idle_pct = 50;
    add_cmd(mse_pkg::MODE_PUSH, 3'd0, $urandom);
    add_cmd(mse_pkg::MODE_DUMP, 3'd0, '0);
    add_cmd(mse_pkg::MODE_POP, 3'd0, '0);
    add_random_cmds(RAND_ITEMS);
    wait_drained();

    // phase 3: random capacities, back-to-back items
    for (int i = 0; i < mse_pkg::NUM_CAP_REGS; i++)
      write_capacity(mse_pkg::CFG_IDX_W'(i),
                     mse_pkg::CAP_W'($urandom_range((1 << mse_pkg::CAP_W) - 1)));
    write_capacity(CFG_IDX_UNUSED,
                   mse_pkg::CAP_W'($urandom_range((1 << mse_pkg::CAP_W) - 1)));
    idle_pct = 0;
    add_random_cmds(RAND_ITEMS);
    wait_drained();

    if (expected_resp.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_resp.size());
    end
    if (mismatch_count == 0) begin
      $display("multi_stack_engine_tb passed");
    end else begin
      $display("multi_stack_engine_tb failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("multi_stack_engine_tb failed");
    $finish;
  end

endmodule

FILE: files.f
sv/mse_pkg.sv
sv/multi_stack_engine.sv
tb/multi_stack_engine_tb.sv
